### sv/skvt_pkg.sv
// Package with shared types, sizes and codes for the sorted key/value table.
`timescale 1ns / 1ps
package skvt_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_LOOKUP = 2'd2;
   localparam logic [1:0] REQ_LIST   = 2'd3;

   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_DUP      = 3'd1;
   localparam logic [2:0] STAT_FULL     = 3'd2;
   localparam logic [2:0] STAT_NOTFOUND = 3'd3;
   localparam logic [2:0] STAT_ENTRY    = 3'd4;
   localparam logic [2:0] STAT_EMPTY    = 3'd5;

   typedef logic [71:0] word72_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] key_head;
      logic [7:0]  key_tail;
      logic [63:0] value_head;
      logic [7:0]  value_tail;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] out_key_head;
      logic [7:0]  out_key_tail;
      logic [63:0] out_value_head;
      logic [7:0]  out_value_tail;
      logic [4:0]  entry_count;
      logic        last;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      word72_type  key;
      word72_type  value;
   } cell_ctl_type;

   typedef struct packed {
      logic eq;
      logic gt;
   } cell_flag_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_EXEC,
      S_LIST
   } state_type;

endpackage

### sv/skvt_cell.sv
// One storage cell of the sorted chain: holds an entry, compares it and shifts it.
`timescale 1ns / 1ps
module skvt_cell (
   input  logic                  clock,
   input  skvt_pkg::cell_ctl_type ctl,
   input  logic                  valid,
   input  skvt_pkg::word72_type  left_key,
   input  skvt_pkg::word72_type  left_value,
   input  logic                  left_gt,
   input  skvt_pkg::word72_type  right_key,
   input  skvt_pkg::word72_type  right_value,
   output skvt_pkg::word72_type  key,
   output skvt_pkg::word72_type  value,
   output skvt_pkg::cell_flag_type flag
);
   import skvt_pkg::*;

   word72_type    key_ff, key_in;
   word72_type    value_ff, value_in;
   cell_flag_type flag_ff, flag_in;

   always_comb begin
      flag_in.eq = valid && (key_ff == ctl.key);
      flag_in.gt = !valid || (key_ff > ctl.key);
   end

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      case (ctl.op)
         CELL_HOLD: begin
            key_in   = key_ff;
            value_in = value_ff;
         end
         CELL_INSERT: begin
            if (flag_ff.gt) begin
               if (left_gt) begin
                  key_in   = left_key;
                  value_in = left_value;
               end else begin
                  key_in   = ctl.key;
                  value_in = ctl.value;
               end
            end
         end
         CELL_DELETE: begin
            if (flag_ff.gt || flag_ff.eq) begin
               key_in   = right_key;
               value_in = right_value;
            end
         end
         CELL_ROTATE: begin
            key_in   = right_key;
            value_in = right_value;
         end
         default: begin
            key_in   = key_ff;
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      flag_ff  <= flag_in;
   end

   assign key   = key_ff;
   assign value = value_ff;
   assign flag  = flag_ff;

endmodule

### sv/skvt_ctrl.sv
// Request sequencer, entry count and result register for the sorted key/value table.
`timescale 1ns / 1ps
module skvt_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  skvt_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output skvt_pkg::rsp_payload_type rsp_payload,
   input  skvt_pkg::cell_flag_type   cell_flag [skvt_pkg::DEPTH],
   input  skvt_pkg::word72_type      cell_value [skvt_pkg::DEPTH],
   input  skvt_pkg::word72_type      head_key,
   input  skvt_pkg::word72_type      head_value,
   output skvt_pkg::cell_ctl_type    cell_ctl,
   output logic [skvt_pkg::CNT_W-1:0] count
);
   import skvt_pkg::*;

   state_type       state_ff, state_in;
   req_payload_type req_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic       any_eq;
   word72_type lookup_value;
   logic       out_free;
   logic       list_emit;
   logic       list_done;
   logic       list_move;
   logic       emit;

   always_comb begin
      any_eq       = 1'b0;
      lookup_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         any_eq       = any_eq | cell_flag[i].eq;
         lookup_value = lookup_value | (cell_flag[i].eq ? cell_value[i] : '0);
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign list_emit = CNT_W'(step_ff) < count_ff;
   assign list_done = step_ff == IDX_W'(DEPTH - 1);
   assign list_move = !list_emit || out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_COMPARE;
         end
         S_COMPARE: state_in = S_EXEC;
         S_EXEC: begin
            if (out_free) begin
               if (req_ff.req_type == REQ_LIST && count_ff != '0) state_in = S_LIST;
               else state_in = S_IDLE;
            end
         end
         S_LIST: begin
            if (list_move && list_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = state_ff == S_IDLE;
      cell_ctl.op    = CELL_HOLD;
      cell_ctl.key   = {req_ff.key_head, req_ff.key_tail};
      cell_ctl.value = {req_ff.value_head, req_ff.value_tail};
      emit         = 1'b0;
      rsp_in       = '0;
      count_in     = count_ff;
      step_in      = step_ff;
      case (state_ff)
         S_EXEC: begin
            step_in = '0;
            if (out_free) begin
               rsp_in.last = 1'b1;
               case (req_ff.req_type)
                  REQ_INSERT: begin
                     emit = 1'b1;
                     if (any_eq) begin
                        rsp_in.status = STAT_DUP;
                     end else if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        rsp_in.status = STAT_OK;
                        cell_ctl.op   = CELL_INSERT;
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end
                  REQ_DELETE: begin
                     emit = 1'b1;
                     if (any_eq) begin
                        rsp_in.status = STAT_OK;
                        cell_ctl.op   = CELL_DELETE;
                        count_in      = count_ff - CNT_W'(1);
                     end else begin
                        rsp_in.status = STAT_NOTFOUND;
                     end
                  end
                  REQ_LOOKUP: begin
                     emit = 1'b1;
                     if (any_eq) begin
                        rsp_in.status         = STAT_OK;
                        rsp_in.out_value_head = lookup_value[71:8];
                        rsp_in.out_value_tail = lookup_value[7:0];
                     end else begin
                        rsp_in.status = STAT_NOTFOUND;
                     end
                  end
                  REQ_LIST: begin
                     if (count_ff == '0) begin
                        emit          = 1'b1;
                        rsp_in.status = STAT_EMPTY;
                     end
                  end
                  default: emit = 1'b0;
               endcase
            end
         end
         S_LIST: begin
            if (list_move) begin
               cell_ctl.op = CELL_ROTATE;
               step_in     = step_ff + IDX_W'(1);
               if (list_emit) begin
                  emit                  = 1'b1;
                  rsp_in.status         = STAT_ENTRY;
                  rsp_in.out_key_head   = head_key[71:8];
                  rsp_in.out_key_tail   = head_key[7:0];
                  rsp_in.out_value_head = head_value[71:8];
                  rsp_in.out_value_tail = head_value[7:0];
                  rsp_in.last           = (CNT_W'(step_ff) + CNT_W'(1)) == count_ff;
               end
            end
         end
         default: emit = 1'b0;
      endcase
      rsp_in.entry_count = 5'(count_in);
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_payload;
      if (emit) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign count       = count_ff;

endmodule

### sv/sorted_key_value_table.sv
// Top level of the sorted key/value table: sequencer and chain of storage cells.
// The req_ channel carries one request per transfer: insert, delete, lookup or list,
// with a 72-bit key and, for insert, a 72-bit value. The rsp_ channel returns one
// result per transfer with a status, key and value fields, the entry count after
// the request and a last flag on the final result of the request.
// Entries live in a chain of DEPTH cells kept in ascending key order. Each cell
// compares its key with the request key in parallel, and insert or delete moves
// every affected entry one cell at once.
// Insert, delete and lookup step through compare and execute: the cells register
// their compare flags, then the result register takes the result once it is free.
// The block takes a new request only when the sequencer is idle again.
// List walks the chain by rotating it one cell per cycle unless a waiting result
// holds it, and it produces one result per stored entry, or one empty result for
// an empty table. The next request is taken once the sequencer is idle again,
// even while the last result still waits. A stalled receiver holds the rotation;
// no result is dropped. Reset empties the table at once; no clearing pass is needed.
`timescale 1ns / 1ps
module sorted_key_value_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  skvt_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output skvt_pkg::rsp_payload_type rsp_payload
);
   import skvt_pkg::*;

   cell_ctl_type     cell_ctl;
   logic [CNT_W-1:0] count;
   cell_flag_type    cell_flag [DEPTH];
   word72_type       cell_key [DEPTH];
   word72_type       cell_value [DEPTH];
   logic [DEPTH-1:0] cell_valid;

   skvt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .cell_flag   (cell_flag),
      .cell_value  (cell_value),
      .head_key    (cell_key[0]),
      .head_value  (cell_value[0]),
      .cell_ctl    (cell_ctl),
      .count       (count)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int LEFT  = (i == 0) ? 0 : i - 1;
      localparam int RIGHT = (i == DEPTH - 1) ? 0 : i + 1;

      assign cell_valid[i] = (CNT_W + 1)'(i) < {1'b0, count};

      skvt_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .valid       (cell_valid[i]),
         .left_key    (cell_key[LEFT]),
         .left_value  (cell_value[LEFT]),
         .left_gt     ((i == 0) ? 1'b0 : cell_flag[LEFT].gt),
         .right_key   (cell_key[RIGHT]),
         .right_value (cell_value[RIGHT]),
         .key         (cell_key[i]),
         .value       (cell_value[i]),
         .flag        (cell_flag[i])
      );
   end

endmodule

### tb/sorted_key_value_table_test.sv
// Self-checking testbench for the sorted key/value table with a built-in table predictor.
`timescale 1ns / 1ps
module sorted_key_value_table_test;
   import skvt_pkg::*;

   localparam int POOL_SIZE = 24;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   req_payload_type pending_requests[$];
   rsp_payload_type expected_results[$];
   word72_type      table_keys[DEPTH];
   word72_type      table_values[DEPTH];
   int              table_count = 0;
   word72_type      key_pool[POOL_SIZE];
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              error_count = 0;
   logic            req_transfer = 1'b0;

   sorted_key_value_table u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic word72_type random_word();
      return {$urandom, $urandom, 8'($urandom)};
   endfunction

   function automatic req_payload_type make_request(logic [1:0] kind, word72_type key,
                                                    word72_type val);
      req_payload_type r;
      r.req_type = kind;
      {r.key_head, r.key_tail} = key;
      {r.value_head, r.value_tail} = val;
      return r;
   endfunction

   // Updates the table copy for one accepted request and queues the results it causes.
   function automatic void predict_table_results(req_payload_type r);
      word72_type      key;
      word72_type      val;
      rsp_payload_type res;
      int              idx;
      int              i;
      key = {r.key_head, r.key_tail};
      val = {r.value_head, r.value_tail};
      idx = -1;
      for (i = 0; i < table_count; i++) begin
         if (table_keys[i] == key) idx = i;
      end
      res = '0;
      res.last = 1'b1;
      case (r.req_type)
         REQ_INSERT: begin
            if (idx >= 0) begin
               res.status = STAT_DUP;
            end else if (table_count >= DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               for (i = table_count; i > 0 && key < table_keys[i - 1]; i--) begin
                  table_keys[i] = table_keys[i - 1];
                  table_values[i] = table_values[i - 1];
               end
               table_keys[i] = key;
               table_values[i] = val;
               table_count++;
               res.status = STAT_OK;
            end
         end
         REQ_DELETE: begin
            if (idx < 0) begin
               res.status = STAT_NOTFOUND;
            end else begin
               for (i = idx; i + 1 < table_count; i++) begin
                  table_keys[i] = table_keys[i + 1];
                  table_values[i] = table_values[i + 1];
               end
               table_count--;
               res.status = STAT_OK;
            end
         end
         REQ_LOOKUP: begin
            if (idx < 0) begin
               res.status = STAT_NOTFOUND;
            end else begin
               res.status = STAT_OK;
               {res.out_value_head, res.out_value_tail} = table_values[idx];
            end
         end
         default: begin
            if (table_count == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               for (i = 0; i < table_count; i++) begin
                  res.status = STAT_ENTRY;
                  {res.out_key_head, res.out_key_tail} = table_keys[i];
                  {res.out_value_head, res.out_value_tail} = table_values[i];
                  res.entry_count = table_count[4:0];
                  res.last = (i + 1 == table_count);
                  expected_results.push_back(res);
               end
               return;
            end
         end
      endcase
      res.entry_count = table_count[4:0];
      expected_results.push_back(res);
   endfunction

   task automatic check_field(string field, logic [71:0] want, logic [71:0] got);
      if (want !== got) begin
         if (error_count < 10) begin
            $display("Mismatch in %s: expected %h, got %h", field, want, got);
         end
         error_count++;
      end
   endtask

   // Most keys come from a small pool so that duplicates, hits and a full table occur.
   task automatic add_random_requests(int count, int insert_pct, int delete_pct);
      int         pick;
      logic [1:0] kind;
      word72_type key;
      repeat (count) begin
         pick = $urandom_range(99);
         key = ($urandom_range(9) == 0) ? random_word() :
               key_pool[$urandom_range(POOL_SIZE - 1)];
         if (pick < insert_pct) begin
            kind = REQ_INSERT;
         end else if (pick < insert_pct + delete_pct) begin
            kind = REQ_DELETE;
         end else if (pick < 88) begin
            kind = REQ_LOOKUP;
         end else begin
            kind = REQ_LIST;
         end
         pending_requests.push_back(make_request(kind, key, random_word()));
      end
   endtask

   task automatic wait_for_drain();
      while (pending_requests.size() > 0 || req_valid) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (!req_valid || req_transfer) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= pending_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      req_transfer <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) predict_table_results(req_payload);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            if (error_count < 10) begin
               $display("Unexpected result transfer: %p", rsp_payload);
            end
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("status", want.status, rsp_payload.status);
            check_field("out_key_head", want.out_key_head, rsp_payload.out_key_head);
            check_field("out_key_tail", want.out_key_tail, rsp_payload.out_key_tail);
            check_field("out_value_head", want.out_value_head, rsp_payload.out_value_head);
            check_field("out_value_tail", want.out_value_tail, rsp_payload.out_value_tail);
            check_field("entry_count", want.entry_count, rsp_payload.entry_count);
            check_field("last", want.last, rsp_payload.last);
         end
      end
   end

   initial begin
      word72_type all_ones;
      all_ones = '1;
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = random_word();
         if (i % 2 == 1) begin
            key_pool[i] = {key_pool[i - 1][71:8],
                           key_pool[i - 1][7:0] ^ 8'($urandom_range(254) + 1)};
         end
      end

      pending_requests.push_back(make_request(REQ_LIST, '0, '0));
      pending_requests.push_back(make_request(REQ_DELETE, '0, all_ones));
      pending_requests.push_back(make_request(REQ_LOOKUP, all_ones, '0));
      pending_requests.push_back(make_request(REQ_INSERT, '0, all_ones));
      pending_requests.push_back(make_request(REQ_INSERT, all_ones, '0));
      pending_requests.push_back(make_request(REQ_INSERT, all_ones, all_ones));
      pending_requests.push_back(make_request(REQ_LOOKUP, all_ones, all_ones));
      pending_requests.push_back(make_request(REQ_LIST, all_ones, all_ones));
      pending_requests.push_back(make_request(REQ_DELETE, '0, '0));
      pending_requests.push_back(make_request(REQ_LOOKUP, '0, '0));
      for (int i = 0; i < DEPTH - 1; i++) begin
         pending_requests.push_back(make_request(REQ_INSERT, key_pool[i], random_word()));
      end
      pending_requests.push_back(make_request(REQ_INSERT, key_pool[DEPTH], random_word()));
      pending_requests.push_back(make_request(REQ_INSERT, all_ones, random_word()));
      pending_requests.push_back(make_request(REQ_LIST, '0, '0));

      send_idle_pct = 23;
      recv_idle_pct = 49;
      add_random_requests(40, 45, 20);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait_for_drain();

      send_idle_pct = 49;
      recv_idle_pct = 23;
      add_random_requests(40, 20, 45);
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_requests(40, 35, 30);
      wait_for_drain();

      while (expected_results.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
